@@ rtl/bsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the microcode program of the banker's allocator.
// Depends on nothing; imported by the interfaces, the allocator and the testbench.
package bsa_pkg;

	// Default sizing and fixed field widths
	localparam int DEF_CUSTOMERS = 5;
	localparam int DEF_RESOURCES = 3;
	localparam int LANES         = 3;
	localparam int UNIT_W        = 8;

	// Item function codes
	typedef enum logic [1:0] {
		FN_DECLARE = 2'd0,
		FN_REQUEST = 2'd1,
		FN_RELEASE = 2'd2,
		FN_UNUSED  = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_OVER_CLAIM = 3'd1,
		ST_OVER_FREE  = 3'd2,
		ST_UNSAFE     = 3'd3,
		ST_BAD        = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TOTAL_0 = 2'd0,
		CFG_TOTAL_1 = 2'd1,
		CFG_TOTAL_2 = 2'd2,
		CFG_SPARE   = 2'd3
	} cfg_idx_t;

	// Datapath action of one microcode step
	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_SUM_CLR   = 4'd1,
		ACT_SUM_ADD   = 4'd2,
		ACT_DISPATCH  = 4'd3,
		ACT_CHECK     = 4'd4,
		ACT_GRANT     = 4'd5,
		ACT_SAFE_STEP = 4'd6,
		ACT_VERDICT   = 4'd7,
		ACT_EMIT      = 4'd8
	} act_t;

	// Sequencing of one microcode step
	typedef enum logic [2:0] {
		SEQ_NEXT      = 3'd0,
		SEQ_LOOP_IDX  = 3'd1,
		SEQ_LOOP_SAFE = 3'd2,
		SEQ_BR_NREQ   = 3'd3,
		SEQ_BR_FAIL   = 3'd4,
		SEQ_END       = 3'd5
	} seq_t;

	typedef logic [3:0] upc_t;

	// Microcode addresses
	localparam upc_t U_SUM_CLR   = 4'd0;
	localparam upc_t U_SUM_ADD   = 4'd1;
	localparam upc_t U_DISPATCH  = 4'd2;
	localparam upc_t U_CHECK     = 4'd3;
	localparam upc_t U_GRANT     = 4'd4;
	localparam upc_t U_SAFE      = 4'd5;
	localparam upc_t U_VERDICT   = 4'd6;
	localparam upc_t U_SUM2_CLR  = 4'd7;
	localparam upc_t U_SUM2_ADD  = 4'd8;
	localparam upc_t U_EMIT      = 4'd9;

	typedef struct packed {
		act_t act;
		seq_t seq;
		upc_t target;
	} ucw_t;

	// Control store: one control word per step
	function automatic ucw_t ucode_rom(input upc_t upc);
		ucw_t w;
		w = '{act: ACT_NONE, seq: SEQ_END, target: U_SUM_CLR};
		case (upc)
			U_SUM_CLR:  w = '{act: ACT_SUM_CLR,   seq: SEQ_NEXT,      target: U_SUM_CLR};
			U_SUM_ADD:  w = '{act: ACT_SUM_ADD,   seq: SEQ_LOOP_IDX,  target: U_SUM_CLR};
			U_DISPATCH: w = '{act: ACT_DISPATCH,  seq: SEQ_BR_NREQ,   target: U_SUM2_CLR};
			U_CHECK:    w = '{act: ACT_CHECK,     seq: SEQ_BR_FAIL,   target: U_SUM2_CLR};
			U_GRANT:    w = '{act: ACT_GRANT,     seq: SEQ_NEXT,      target: U_SUM_CLR};
			U_SAFE:     w = '{act: ACT_SAFE_STEP, seq: SEQ_LOOP_SAFE, target: U_SUM_CLR};
			U_VERDICT:  w = '{act: ACT_VERDICT,   seq: SEQ_NEXT,      target: U_SUM_CLR};
			U_SUM2_CLR: w = '{act: ACT_SUM_CLR,   seq: SEQ_NEXT,      target: U_SUM_CLR};
			U_SUM2_ADD: w = '{act: ACT_SUM_ADD,   seq: SEQ_LOOP_IDX,  target: U_SUM_CLR};
			U_EMIT:     w = '{act: ACT_EMIT,      seq: SEQ_END,       target: U_SUM_CLR};
			default:    w = '{act: ACT_NONE,      seq: SEQ_END,       target: U_SUM_CLR};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/bsa_cmd_if.sv @@
`timescale 1ns / 1ps
// Command channel: one word per allocator item, valid/ready handshake.
// Depends on bsa_pkg for the field widths.
interface bsa_cmd_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [2:0]        customer;
	logic [UNIT_W-1:0] amount_0;
	logic [UNIT_W-1:0] amount_1;
	logic [UNIT_W-1:0] amount_2;
	logic [UNIT_W-1:0] held_0;
	logic [UNIT_W-1:0] held_1;
	logic [UNIT_W-1:0] held_2;

	modport source (output valid, func, customer, amount_0, amount_1, amount_2,
		held_0, held_1, held_2, input ready);
	modport sink (input valid, func, customer, amount_0, amount_1, amount_2,
		held_0, held_1, held_2, output ready);
endinterface

@@ rtl/bsa_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: status and free units after each item, valid/ready.
// Depends on bsa_pkg for the field widths.
interface bsa_rsp_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [UNIT_W-1:0] free_0;
	logic [UNIT_W-1:0] free_1;
	logic [UNIT_W-1:0] free_2;

	modport source (output valid, status, free_0, free_1, free_2, input ready);
	modport sink (input valid, status, free_0, free_1, free_2, output ready);
endinterface

@@ rtl/bsa_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: register index and data, valid/ready.
// Depends on bsa_pkg for the data width.
interface bsa_cfg_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        index;
	logic [UNIT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bankers_safe_allocator.sv @@
`timescale 1ns / 1ps
// Banker's deadlock-avoidance allocator, microcoded: sequencer plus table datapath.
// Depends on bsa_pkg and the bsa_cmd_if, bsa_rsp_if and bsa_cfg_if interfaces.
//
//   channel  role   word
//   cmd      sink   func, customer, amount_0..2, held_0..2
//   rsp      source status, free_0..2
//   cfg      sink   index, data (total units of a resource type)
//
// Each item runs through the steps: sum the held units, dispatch (declare, release
// and rejected items skip ahead to the second sum), the claim and free check (a
// failing request skips ahead too), then for a checked request the grant, the
// safety scan, one customer per cycle over C passes, and the verdict with rollback;
// every item ends by summing again and emitting the reply word (C = CUSTOMERS).
// Reset clears all tables and totals. One item is in work at a time; the response
// register holds a finished word while the next item runs, and the last step waits until it is free.
module bankers_safe_allocator
	import bsa_pkg::*;
#(
	parameter int CUSTOMERS = DEF_CUSTOMERS,
	parameter int RESOURCES = DEF_RESOURCES
) (
	input  logic        clk,
	input  logic        arst_n,
	bsa_cmd_if.sink     cmd,
	bsa_rsp_if.source   rsp,
	bsa_cfg_if.sink     cfg
);

	localparam int IW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
	localparam int SW = $clog2(CUSTOMERS * 255 + 1);
	localparam int WW = $clog2((CUSTOMERS + 1) * 255 + 1);
	localparam logic [IW-1:0] LAST_IX = IW'(CUSTOMERS - 1);

	// Configuration and tables
	logic [UNIT_W-1:0] total_q [LANES];
	logic [UNIT_W-1:0] max_q  [CUSTOMERS][RESOURCES];
	logic [UNIT_W-1:0] held_q [CUSTOMERS][RESOURCES];
	logic [UNIT_W-1:0] rem_q  [CUSTOMERS][RESOURCES];

	// Captured item
	func_t             func_q;
	logic [2:0]        cust_q;
	logic [UNIT_W-1:0] amt_q [LANES];
	logic [UNIT_W-1:0] hld_q [LANES];

	// Sequencer and datapath registers
	logic              busy_q;
	upc_t              upc_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     pass_q;
	logic [SW-1:0]     sum_q  [RESOURCES];
	logic [WW-1:0]     work_q [RESOURCES];
	logic [CUSTOMERS-1:0] done_q;
	status_t           status_q;

	// Response register
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [UNIT_W-1:0] rsp_free_q [LANES];

	ucw_t              ucw;
	logic              cmd_acc;
	logic              cust_ok;
	logic              is_req;
	logic              idx_last;
	logic              pass_last;
	logic              slot_free;
	logic [IW-1:0]     cust_ix;
	logic [IW-1:0]     rd_ix;
	logic [UNIT_W-1:0] free_w [RESOURCES];
	logic              decl_bad;
	logic              chk_fail;
	status_t           chk_code;
	logic              fits;
	logic              all_done;

	// Row write port
	logic              wr_en;
	logic [UNIT_W-1:0] wr_max  [RESOURCES];
	logic [UNIT_W-1:0] wr_held [RESOURCES];
	logic [UNIT_W-1:0] wr_rem  [RESOURCES];

	assign ucw       = ucode_rom(upc_q);
	assign cmd.ready = !busy_q;
	assign cmd_acc   = cmd.valid && !busy_q;
	assign cfg.ready = 1'b1;
	assign cust_ok   = ({2'b0, cust_q} < 5'(CUSTOMERS));
	assign is_req    = cust_ok && (func_q == FN_REQUEST);
	assign cust_ix   = IW'(cust_q);
	assign idx_last  = (idx_q == LAST_IX);
	assign pass_last = (pass_q == LAST_IX);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign all_done  = &done_q;

	// Pick the row address: customer of the item, or the scan index
	always_comb begin
		rd_ix = idx_q;
		if (ucw.act == ACT_DISPATCH || ucw.act == ACT_CHECK || ucw.act == ACT_GRANT ||
			ucw.act == ACT_VERDICT) begin
			rd_ix = cust_ix;
		end
	end

	// Free units from the held sums, saturating at zero
	always_comb begin
		for (int r = 0; r < RESOURCES; r++) begin
			if (sum_q[r] >= SW'(total_q[r])) begin
				free_w[r] = '0;
			end else begin
				free_w[r] = UNIT_W'(SW'(total_q[r]) - sum_q[r]);
			end
		end
	end

	// Declare check and request checks, types in order 0 upward
	always_comb begin
		decl_bad = 1'b0;
		chk_fail = 1'b0;
		chk_code = ST_DONE;
		fits     = !done_q[rd_ix];
		for (int r = 0; r < RESOURCES; r++) begin
			if (hld_q[r] > amt_q[r]) begin
				decl_bad = 1'b1;
			end
			if (!chk_fail) begin
				if (amt_q[r] > rem_q[rd_ix][r]) begin
					chk_fail = 1'b1;
					chk_code = ST_OVER_CLAIM;
				end else if (amt_q[r] > free_w[r]) begin
					chk_fail = 1'b1;
					chk_code = ST_OVER_FREE;
				end
			end
			if (WW'(rem_q[rd_ix][r]) > work_q[r]) begin
				fits = 1'b0;
			end
		end
	end

	// Build the row write for declare, release, grant and rollback
	always_comb begin
		wr_en = 1'b0;
		for (int r = 0; r < RESOURCES; r++) begin
			wr_max[r]  = max_q[rd_ix][r];
			wr_held[r] = held_q[rd_ix][r];
			wr_rem[r]  = rem_q[rd_ix][r];
		end
		case (ucw.act)
			ACT_DISPATCH: begin
				if (cust_ok && func_q == FN_DECLARE && !decl_bad) begin
					wr_en = 1'b1;
					for (int r = 0; r < RESOURCES; r++) begin
						wr_max[r]  = amt_q[r];
						wr_held[r] = hld_q[r];
						wr_rem[r]  = amt_q[r] - hld_q[r];
					end
				end else if (cust_ok && func_q == FN_RELEASE) begin
					wr_en = 1'b1;
					for (int r = 0; r < RESOURCES; r++) begin
						wr_held[r] = '0;
						wr_rem[r]  = max_q[rd_ix][r];
					end
				end
			end
			ACT_GRANT: begin
				wr_en = 1'b1;
				for (int r = 0; r < RESOURCES; r++) begin
					wr_held[r] = held_q[rd_ix][r] + amt_q[r];
					wr_rem[r]  = rem_q[rd_ix][r] - amt_q[r];
				end
			end
			ACT_VERDICT: begin
				if (!all_done) begin
					wr_en = 1'b1;
					for (int r = 0; r < RESOURCES; r++) begin
						wr_held[r] = held_q[rd_ix][r] - amt_q[r];
						wr_rem[r]  = rem_q[rd_ix][r] + amt_q[r];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the totals; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LANES; r++) begin
				total_q[r] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TOTAL_0: total_q[0] <= cfg.data;
				CFG_TOTAL_1: total_q[1] <= cfg.data;
				CFG_TOTAL_2: total_q[2] <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Tables, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CUSTOMERS; c++) begin
				for (int r = 0; r < RESOURCES; r++) begin
					max_q[c][r]  <= '0;
					held_q[c][r] <= '0;
					rem_q[c][r]  <= '0;
				end
			end
		end else if (wr_en) begin
			for (int r = 0; r < RESOURCES; r++) begin
				max_q[rd_ix][r]  <= wr_max[r];
				held_q[rd_ix][r] <= wr_held[r];
				rem_q[rd_ix][r]  <= wr_rem[r];
			end
		end
	end

	// Capture the command word
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_q    <= func_t'(cmd.func);
			cust_q    <= cmd.customer;
			amt_q[0]  <= cmd.amount_0;
			amt_q[1]  <= cmd.amount_1;
			amt_q[2]  <= cmd.amount_2;
			hld_q[0]  <= cmd.held_0;
			hld_q[1]  <= cmd.held_1;
			hld_q[2]  <= cmd.held_2;
		end
	end

	// Step counter with loops and conditional jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= U_SUM_CLR;
		end else if (cmd_acc) begin
			busy_q <= 1'b1;
			upc_q  <= U_SUM_CLR;
		end else if (busy_q) begin
			case (ucw.seq)
				SEQ_NEXT: upc_q <= upc_q + 4'd1;
				SEQ_LOOP_IDX: begin
					if (idx_last) begin
						upc_q <= upc_q + 4'd1;
					end
				end
				SEQ_LOOP_SAFE: begin
					if (idx_last && pass_last) begin
						upc_q <= upc_q + 4'd1;
					end
				end
				SEQ_BR_NREQ: upc_q <= is_req ? upc_q + 4'd1 : ucw.target;
				SEQ_BR_FAIL: upc_q <= chk_fail ? ucw.target : upc_q + 4'd1;
				SEQ_END: begin
					if (slot_free) begin
						busy_q <= 1'b0;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

	// Datapath: sums, work vector, scan indexes, status
	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (ucw.act)
				ACT_SUM_CLR: begin
					idx_q <= '0;
					for (int r = 0; r < RESOURCES; r++) begin
						sum_q[r] <= '0;
					end
				end
				ACT_SUM_ADD: begin
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					for (int r = 0; r < RESOURCES; r++) begin
						sum_q[r] <= sum_q[r] + SW'(held_q[rd_ix][r]);
					end
				end
				ACT_DISPATCH: begin
					if (!cust_ok || func_q == FN_UNUSED ||
						(func_q == FN_DECLARE && decl_bad)) begin
						status_q <= ST_BAD;
					end else begin
						status_q <= ST_DONE;
					end
				end
				ACT_CHECK: status_q <= chk_code;
				ACT_GRANT: begin
					idx_q  <= '0;
					pass_q <= '0;
					done_q <= '0;
					for (int r = 0; r < RESOURCES; r++) begin
						work_q[r] <= WW'(free_w[r] - amt_q[r]);
					end
				end
				ACT_SAFE_STEP: begin
					if (idx_last) begin
						idx_q  <= '0;
						pass_q <= pass_q + 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					if (fits) begin
						done_q[rd_ix] <= 1'b1;
						for (int r = 0; r < RESOURCES; r++) begin
							work_q[r] <= work_q[r] + WW'(held_q[rd_ix][r]);
						end
					end
				end
				ACT_VERDICT: status_q <= all_done ? ST_DONE : ST_UNSAFE;
				default: begin
				end
			endcase
		end
	end

	// Response register: load on the last step, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (busy_q && ucw.act == ACT_EMIT && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ucw.act == ACT_EMIT && slot_free) begin
			rsp_status_q <= status_q;
			for (int r = 0; r < LANES; r++) begin
				rsp_free_q[r] <= (r < RESOURCES) ? free_w[r % RESOURCES] : '0;
			end
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.free_0 = rsp_free_q[0];
	assign rsp.free_1 = rsp_free_q[1];
	assign rsp.free_2 = rsp_free_q[2];

endmodule

@@ tb/bsa_grant_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the banker's allocator: follows the config and command words,
// predicts the reply to each command and checks every reply word against it.
// Depends on bsa_pkg and the bsa_cmd_if, bsa_rsp_if and bsa_cfg_if interfaces.
module bsa_grant_checker
	import bsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bsa_cmd_if   cmd,
	bsa_rsp_if   rsp,
	bsa_cfg_if   cfg,
	output int   pending,
	output int   errors
);

	localparam int NC = DEF_CUSTOMERS;
	localparam int NR = DEF_RESOURCES;

	typedef logic [UNIT_W-1:0] units_t;
	typedef logic [NR-1:0][UNIT_W-1:0] unit_vec_t;

	typedef struct packed {
		status_t status;
		units_t  free_0;
		units_t  free_1;
		units_t  free_2;
	} alloc_reply_t;

	units_t       total_units [NR];
	units_t       max_claim [NC][NR];
	units_t       holding [NC][NR];
	units_t       still_claimable [NC][NR];
	alloc_reply_t replies_due [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// Free units of one type: total minus everything held, floored at zero
	function automatic units_t free_units(input int r);
		int sum;
		sum = 0;
		for (int c = 0; c < NC; c++)
			sum += holding[c][r];
		return (sum >= total_units[r]) ? units_t'(0) : units_t'(total_units[r] - sum);
	endfunction

	// Safety scan: NC passes over all customers with a work vector
	function automatic bit state_safe();
		int work [NR];
		bit finished [NC];
		bit fits;
		for (int r = 0; r < NR; r++)
			work[r] = free_units(r);
		for (int c = 0; c < NC; c++)
			finished[c] = 1'b0;
		for (int pass = 0; pass < NC; pass++) begin
			for (int c = 0; c < NC; c++) begin
				if (!finished[c]) begin
					fits = 1'b1;
					for (int r = 0; r < NR; r++)
						if (still_claimable[c][r] > work[r])
							fits = 1'b0;
					if (fits) begin
						finished[c] = 1'b1;
						for (int r = 0; r < NR; r++)
							work[r] += holding[c][r];
					end
				end
			end
		end
		for (int c = 0; c < NC; c++)
			if (!finished[c])
				return 1'b0;
		return 1'b1;
	endfunction

	// Apply one command word to the tables and return its status
	function automatic status_t apply_item(input logic [1:0] fn, input logic [2:0] cust,
		input unit_vec_t amt, input unit_vec_t hld);
		int c;
		c = cust;
		if (c >= NC)
			return ST_BAD;
		case (func_t'(fn))
			FN_DECLARE: begin
				for (int r = 0; r < NR; r++)
					if (hld[r] > amt[r])
						return ST_BAD;
				for (int r = 0; r < NR; r++) begin
					max_claim[c][r] = amt[r];
					holding[c][r] = hld[r];
					still_claimable[c][r] = amt[r] - hld[r];
				end
				return ST_DONE;
			end
			FN_REQUEST: begin
				// claim and free checks interleave per type, lowest type first
				for (int r = 0; r < NR; r++) begin
					if (amt[r] > still_claimable[c][r])
						return ST_OVER_CLAIM;
					if (amt[r] > free_units(r))
						return ST_OVER_FREE;
				end
				for (int r = 0; r < NR; r++) begin
					holding[c][r] = holding[c][r] + amt[r];
					still_claimable[c][r] = still_claimable[c][r] - amt[r];
				end
				if (state_safe())
					return ST_DONE;
				// roll back the tentative grant
				for (int r = 0; r < NR; r++) begin
					holding[c][r] = holding[c][r] - amt[r];
					still_claimable[c][r] = still_claimable[c][r] + amt[r];
				end
				return ST_UNSAFE;
			end
			FN_RELEASE: begin
				for (int r = 0; r < NR; r++) begin
					holding[c][r] = '0;
					still_claimable[c][r] = max_claim[c][r];
				end
				return ST_DONE;
			end
			default: return ST_BAD;
		endcase
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: reply %s mismatch, expected %0d actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		alloc_reply_t due;
		unit_vec_t    amt;
		unit_vec_t    hld;
		if (!arst_n) begin
			for (int r = 0; r < NR; r++)
				total_units[r] = '0;
			for (int c = 0; c < NC; c++) begin
				for (int r = 0; r < NR; r++) begin
					max_claim[c][r] = '0;
					holding[c][r] = '0;
					still_claimable[c][r] = '0;
				end
			end
			replies_due.delete();
			pending = 0;
		end else begin
			// compare a reply word with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with nothing expected, expected none actual status %0d",
						$time, rsp.status);
					errors++;
				end else begin
					due = replies_due.pop_front();
					check_field("status", due.status, rsp.status);
					check_field("free_0", due.free_0, rsp.free_0);
					check_field("free_1", due.free_1, rsp.free_1);
					check_field("free_2", due.free_2, rsp.free_2);
				end
			end
			// track config writes; the spare index has no register
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_TOTAL_0: total_units[0] = cfg.data;
					CFG_TOTAL_1: total_units[1] = cfg.data;
					CFG_TOTAL_2: total_units[2] = cfg.data;
					default: ;
				endcase
			end
			// predict the reply to an accepted command word
			if (cmd.valid && cmd.ready) begin
				amt = {cmd.amount_2, cmd.amount_1, cmd.amount_0};
				hld = {cmd.held_2, cmd.held_1, cmd.held_0};
				due.status = apply_item(cmd.func, cmd.customer, amt, hld);
				due.free_0 = free_units(0);
				due.free_1 = free_units(1);
				due.free_2 = free_units(2);
				replies_due.push_back(due);
			end
			pending = replies_due.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command, config and reply
// traffic, watchdog and verdict. Depends on bsa_pkg, the channel interfaces,
// bankers_safe_allocator and the bsa_grant_checker scoreboard.
module tb_top;
	import bsa_pkg::*;

	localparam int ITEM_CYCLES = DEF_CUSTOMERS * DEF_CUSTOMERS + 2 * DEF_CUSTOMERS + 7;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + 2 * ITEM_CYCLES + 20);
	localparam int PHASE_ITEMS = 280;
	localparam int PHASES      = 6;

	typedef logic [UNIT_W-1:0] units_t;

	logic   clk;
	logic   arst_n;
	int     pending;
	int     errors;
	bit     hold_replies;
	int     send_quiet;
	int     take_quiet;
	units_t claim_hint [DEF_CUSTOMERS][DEF_RESOURCES];
	units_t total_hint [DEF_RESOURCES];

	bsa_cmd_if cmd ();
	bsa_rsp_if rsp ();
	bsa_cfg_if cfg ();

	bankers_safe_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	bsa_grant_checker scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.cfg     (cfg),
		.pending (pending),
		.errors  (errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
	end

	// Idle cycles before the next word: mostly 0..5, with runs of no idling
	function automatic int next_gap(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	// Reply side: stall at random, hold off once for a long stretch
	initial begin : reply_side
		int gap;
		rsp.ready = 1'b0;
		take_quiet = 0;
		@(posedge arst_n);
		forever begin
			if (hold_replies) begin
				gap = HOLD_CYCLES;
				hold_replies = 1'b0;
			end else begin
				gap = next_gap(take_quiet);
			end
			if (gap > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	task automatic send_item(input func_t fn, input logic [2:0] cust,
		input units_t a0, a1, a2, h0, h1, h2);
		int gap;
		gap = next_gap(send_quiet);
		if (gap > 0) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd.valid    <= 1'b1;
		cmd.func     <= fn;
		cmd.customer <= cust;
		cmd.amount_0 <= a0;
		cmd.amount_1 <= a1;
		cmd.amount_2 <= a2;
		cmd.held_0   <= h0;
		cmd.held_1   <= h1;
		cmd.held_2   <= h2;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Drop the command valid and wait until every reply is back
	task automatic wait_replies();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input units_t value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_totals(input units_t t0, input units_t t1, input units_t t2);
		wait_replies();
		write_reg(CFG_TOTAL_0, t0);
		write_reg(CFG_TOTAL_1, t1);
		write_reg(CFG_TOTAL_2, t2);
		total_hint[0] = t0;
		total_hint[1] = t1;
		total_hint[2] = t2;
	endtask

	// Well-formed declare: claim within the totals (up to 3 where a total is zero), light initial holding
	task automatic declare_one(input int c);
		units_t m [DEF_RESOURCES];
		units_t h [DEF_RESOURCES];
		int cap;
		for (int r = 0; r < DEF_RESOURCES; r++) begin
			cap = (total_hint[r] == 0) ? 3 : total_hint[r];
			m[r] = UNIT_W'($urandom_range(0, cap));
			h[r] = UNIT_W'($urandom_range(0, m[r] / 4));
			claim_hint[c][r] = m[r];
		end
		send_item(FN_DECLARE, 3'(c), m[0], m[1], m[2], h[0], h[1], h[2]);
	endtask

	task automatic random_item();
		int pick;
		int c;
		int lim;
		int bad_r;
		units_t a [DEF_RESOURCES];
		units_t h [DEF_RESOURCES];
		pick = $urandom_range(0, 99);
		c = $urandom_range(0, DEF_CUSTOMERS - 1);
		for (int r = 0; r < DEF_RESOURCES; r++) begin
			a[r] = UNIT_W'($urandom);
			h[r] = UNIT_W'($urandom);
		end
		if (pick < 58) begin
			// request within the declared claim, mostly a few units
			for (int r = 0; r < DEF_RESOURCES; r++) begin
				lim = claim_hint[c][r];
				if ($urandom_range(0, 1) == 0 && lim > 3)
					lim = 3;
				a[r] = UNIT_W'($urandom_range(0, lim));
			end
			send_item(FN_REQUEST, 3'(c), a[0], a[1], a[2], h[0], h[1], h[2]);
		end else if (pick < 70) begin
			send_item(FN_RELEASE, 3'(c), a[0], a[1], a[2], h[0], h[1], h[2]);
		end else if (pick < 82) begin
			declare_one(c);
		end else if (pick < 88) begin
			// declare with one holding above its claim
			bad_r = $urandom_range(0, DEF_RESOURCES - 1);
			for (int r = 0; r < DEF_RESOURCES; r++) begin
				a[r] = UNIT_W'($urandom_range(0, 254));
				h[r] = (r == bad_r) ? UNIT_W'($urandom_range(a[r] + 1, 255)) : UNIT_W'(0);
			end
			send_item(FN_DECLARE, 3'(c), a[0], a[1], a[2], h[0], h[1], h[2]);
		end else if (pick < 95) begin
			send_item(func_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
				a[0], a[1], a[2], h[0], h[1], h[2]);
		end else if (pick < 98) begin
			send_item(func_t'($urandom_range(0, 3)), 3'($urandom_range(DEF_CUSTOMERS, 7)),
				a[0], a[1], a[2], h[0], h[1], h[2]);
		end else begin
			send_item(FN_UNUSED, 3'(c), a[0], a[1], a[2], h[0], h[1], h[2]);
		end
	endtask

	// Stimulus: directed words first, then random phases over several totals
	initial begin : stimulus
		cmd.valid    = 1'b0;
		cmd.func     = FN_DECLARE;
		cmd.customer = '0;
		cmd.amount_0 = '0;
		cmd.amount_1 = '0;
		cmd.amount_2 = '0;
		cmd.held_0   = '0;
		cmd.held_1   = '0;
		cmd.held_2   = '0;
		cfg.valid    = 1'b0;
		cfg.index    = CFG_TOTAL_0;
		cfg.data     = '0;
		hold_replies = 1'b0;
		send_quiet   = 0;
		for (int c = 0; c < DEF_CUSTOMERS; c++)
			for (int r = 0; r < DEF_RESOURCES; r++)
				claim_hint[c][r] = '0;
		@(posedge arst_n);

		// the spare index holds no register
		write_reg(CFG_SPARE, 8'hA5);
		set_totals(8'd10, 8'd5, 8'd7);

		// requests against empty tables: zero grant, then over claim
		send_item(FN_REQUEST, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_REQUEST, 3'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// textbook five-customer snapshot
		send_item(FN_DECLARE, 3'd0, 8'd7, 8'd5, 8'd3, 8'd0, 8'd1, 8'd0);
		send_item(FN_DECLARE, 3'd1, 8'd3, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0);
		send_item(FN_DECLARE, 3'd2, 8'd9, 8'd0, 8'd2, 8'd3, 8'd0, 8'd2);
		send_item(FN_DECLARE, 3'd3, 8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1);
		send_item(FN_DECLARE, 3'd4, 8'd4, 8'd3, 8'd3, 8'd0, 8'd0, 8'd2);
		// safe grant, over free, unsafe rolled back, over claim on type 2
		send_item(FN_REQUEST, 3'd1, 8'd1, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0);
		send_item(FN_REQUEST, 3'd4, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_REQUEST, 3'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_REQUEST, 3'd2, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0);
		// holding above claim, bad customer, unused function
		send_item(FN_DECLARE, 3'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1);
		send_item(FN_REQUEST, 3'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_RELEASE, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_item(FN_UNUSED, 3'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// release ignores its amounts
		send_item(FN_RELEASE, 3'd2, 8'd255, 8'd170, 8'd85, 8'd255, 8'd170, 8'd85);
		send_item(FN_REQUEST, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		// held sum past the totals: free saturates at zero
		send_item(FN_DECLARE, 3'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_item(FN_REQUEST, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// type 0 over free reported before type 1 over claim
		send_item(FN_REQUEST, 3'd0, 8'd1, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_RELEASE, 3'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_DECLARE, 3'd4, 8'd0, 8'd255, 8'd170, 8'd0, 8'd85, 8'd170);
		send_item(FN_RELEASE, 3'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(FN_RELEASE, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_totals(8'd255, 8'd255, 8'd255);
				1: set_totals(8'd0, 8'd0, 8'd0);
				2: set_totals(UNIT_W'($urandom_range(1, 20)), UNIT_W'($urandom_range(1, 20)),
					UNIT_W'($urandom_range(1, 20)));
				3: set_totals(8'd0, 8'd255, 8'd1);
				4: set_totals(UNIT_W'($urandom), UNIT_W'($urandom), UNIT_W'($urandom));
				default: set_totals(UNIT_W'($urandom_range(4, 40)),
					UNIT_W'($urandom_range(4, 40)), UNIT_W'($urandom_range(4, 40)));
			endcase
			for (int c = 0; c < DEF_CUSTOMERS; c++)
				declare_one(c);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off replies while commands keep coming
				if (phase == 1 && i == 100)
					hold_replies = 1'b1;
				// pause commands until the block has drained
				if (phase == 3 && i == 150)
					wait_replies();
				random_item();
			end
		end

		wait_replies();
		repeat (2 * ITEM_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: end the run after too long with no word moving
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
